// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the project.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/nsv_pkg.sv =====
// Shared types, constants and the seed merge function of the Voronoi labeler.
// Depends on nothing; used by every module of the block.
package nsv_pkg;

    localparam int MAX_SEEDS_DEF = 64;
    localparam int GRID_SIZE_DEF = 256;

    localparam int COUNT_W = 7;
    localparam int IDX_W   = 6;
    localparam int COORD_W = 8;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 17;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic [COUNT_W-1:0] SEED_COUNT_RST = 7'd40;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // One item in flight, with the squares of the seed it meets next
    typedef struct packed {
        logic               func;
        logic [IDX_W-1:0]   slot;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic               lab;
        logic [SQ_W-1:0]    sq_x;
        logic [SQ_W-1:0]    sq_y;
        logic               sq_lab;
        logic [DIST_W-1:0]  best_dist;
        logic [IDX_W-1:0]   best_idx;
        logic               best_lab;
    } nsv_item_t;

    // Merge one seed's registered squares into the running best; lower slot wins ties
    function automatic nsv_item_t fold_seed(input nsv_item_t it, input logic first,
                                            input logic active,
                                            input logic [IDX_W-1:0] idx);
        nsv_item_t         r;
        logic [DIST_W-1:0] d;
        r = it;
        d = {1'b0, it.sq_x} + {1'b0, it.sq_y};
        if (first || (active && (d < it.best_dist))) begin
            r.best_dist = d;
            r.best_idx  = idx;
            r.best_lab  = it.sq_lab;
        end
        return r;
    endfunction

endpackage

// ===== rtl/nearest_seed_voronoi_labeler_core.sv =====
// Top level of the nearest-seed Voronoi labeler: input unpack, seed stage chain, output.
// Depends on nsv_pkg, nsv_cell, nsv_out and assert_macros.svh.
//
// Loads and queries share one stream and flow through a chain of MAX_SEEDS stages, one per
// seed slot, followed by an output register. Each stage keeps one seed, compares the item
// against the previous seed and squares its distance to its own; a load writes its slot as it
// passes that slot's stage, so every query sees exactly the loads that came before it. The
// block takes one item per clock while the output is not stalled; a query is captured by the
// first stage at its transfer, moves through the stage registers in order, and m_tvalid rises
// when it reaches the output register after the last stage. A stall at the output holds
// the whole chain. Loads give no result. The seed_count register (reset 40) is written
// through cfg_valid/cfg_data and must be changed only while the chain is empty.
`include "assert_macros.svh"

module nearest_seed_voronoi_labeler_core #(
    parameter int MAX_SEEDS = nsv_pkg::MAX_SEEDS_DEF,
    parameter int GRID_SIZE = nsv_pkg::GRID_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // seed_index[5:0], coord_x[13:6], coord_y[21:14], seed_label[22], zero[23]
    input  logic [nsv_pkg::S_TDATA_W-1:0] s_tdata,
    // func[0]
    input  logic                          s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // nearest_label[0], nearest_index[6:1], nearest_dist_sq[23:7]
    output logic [nsv_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [nsv_pkg::COUNT_W-1:0]   cfg_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready
);

    localparam logic [nsv_pkg::COORD_W-1:0] COORD_MAX =
        (GRID_SIZE - 1 > 255) ? 8'd255 : nsv_pkg::COORD_W'(GRID_SIZE - 1);

    logic [nsv_pkg::COUNT_W-1:0] seed_count_reg;
    logic                        advance;
    logic [MAX_SEEDS-1:0]        active_vec;
    logic [MAX_SEEDS-1:0]        stage_valid;
    nsv_pkg::nsv_item_t          stage_item [MAX_SEEDS];
    nsv_pkg::nsv_item_t          in_item;
    logic [nsv_pkg::COORD_W-1:0] raw_x;
    logic [nsv_pkg::COORD_W-1:0] raw_y;
    logic                        idx_check_en;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_count_reg <= nsv_pkg::SEED_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            seed_count_reg <= cfg_data;
        end
    end

    // Mark the slots a query compares against; slot 0 always counts
    always_comb begin
        for (int j = 0; j < MAX_SEEDS; j++) begin
            active_vec[j] = (j == 0) || (int'(seed_count_reg) > j);
        end
    end

    // Hold the chain while a result waits
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // Unpack and clamp the incoming transfer
    assign raw_x = s_tdata[13:6];
    assign raw_y = s_tdata[21:14];

    always_comb begin
        in_item      = '0;
        in_item.func = s_tuser;
        in_item.slot = s_tdata[5:0];
        in_item.cx   = (raw_x > COORD_MAX) ? COORD_MAX : raw_x;
        in_item.cy   = (raw_y > COORD_MAX) ? COORD_MAX : raw_y;
        in_item.lab  = s_tdata[22];
    end

    // Seed stage chain
    for (genvar j = 0; j < MAX_SEEDS; j++) begin : g_cell
        if (j == 0) begin : g_first
            nsv_cell #(
                .IDX(j)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .advance    (advance),
                .in_valid   (s_tvalid),
                .in_item    (in_item),
                .active_prev(1'b1),
                .out_valid  (stage_valid[j]),
                .out_item   (stage_item[j])
            );
        end else begin : g_next
            nsv_cell #(
                .IDX(j)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .advance    (advance),
                .in_valid   (stage_valid[j-1]),
                .in_item    (stage_item[j-1]),
                .active_prev(active_vec[j-1]),
                .out_valid  (stage_valid[j]),
                .out_item   (stage_item[j])
            );
        end
    end

    // Final merge and result register
    nsv_out #(
        .MAX_SEEDS(MAX_SEEDS)
    ) u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (stage_valid[MAX_SEEDS-1]),
        .in_item    (stage_item[MAX_SEEDS-1]),
        .active_last(active_vec[MAX_SEEDS-1]),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

    // Check the winning slot only while the count is nonzero and inside the store
    assign idx_check_en = m_tvalid && (seed_count_reg != '0) &&
                          (int'(seed_count_reg) <= MAX_SEEDS);

    // A squared distance of two 8-bit coordinate pairs stays in range
    `ASSERT_SAME(a_dist_range, aclk, aresetn, m_tvalid, m_tdata[23:7] <= 17'd130050)

    // The winning slot lies inside the compared range
    `ASSERT_SAME(a_idx_range, aclk, aresetn, idx_check_en, {1'b0, m_tdata[6:1]} < seed_count_reg)

    // A stalled chain keeps its first stage
    `ASSERT_NEXT(a_stage_hold, aclk, aresetn, !advance && stage_valid[0], stage_valid[0] && $stable(stage_item[0]))

endmodule

// ===== rtl/nsv_cell.sv =====
// One pipeline stage of the labeler: holds seed IDX, merges seed IDX-1, squares seed IDX.
// Depends on nsv_pkg.
module nsv_cell #(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              in_valid,
    input  nsv_pkg::nsv_item_t in_item,
    input  logic              active_prev,
    output logic              out_valid,
    output nsv_pkg::nsv_item_t out_item
);

    localparam int PREV = (IDX > 0) ? IDX - 1 : 0;

    logic [nsv_pkg::COORD_W-1:0] seed_x_reg;
    logic [nsv_pkg::COORD_W-1:0] seed_y_reg;
    logic                        seed_lab_reg;
    logic                        valid_reg;
    nsv_pkg::nsv_item_t          item_reg;
    nsv_pkg::nsv_item_t          item_next;
    logic [nsv_pkg::COORD_W-1:0] dx;
    logic [nsv_pkg::COORD_W-1:0] dy;
    logic                        load_hit;

    // Write the seed when a load for this slot crosses into this stage
    assign load_hit = advance && in_valid && (in_item.func == nsv_pkg::FUNC_LOAD) &&
                      (int'(in_item.slot) == IDX);

    always_ff @(posedge aclk) begin
        if (load_hit) begin
            seed_x_reg   <= in_item.cx;
            seed_y_reg   <= in_item.cy;
            seed_lab_reg <= in_item.lab;
        end
    end

    // Merge the previous seed, then square the distance to this one
    always_comb begin
        dx = (in_item.cx > seed_x_reg) ? (in_item.cx - seed_x_reg) : (seed_x_reg - in_item.cx);
        dy = (in_item.cy > seed_y_reg) ? (in_item.cy - seed_y_reg) : (seed_y_reg - in_item.cy);
        item_next        = nsv_pkg::fold_seed(in_item, (IDX <= 1), active_prev,
                                              nsv_pkg::IDX_W'(PREV));
        item_next.sq_x   = {8'd0, dx} * {8'd0, dx};
        item_next.sq_y   = {8'd0, dy} * {8'd0, dy};
        item_next.sq_lab = seed_lab_reg;
    end

    // Advance the stage register; valid travels with the item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/nsv_out.sv =====
// Output stage of the labeler: merges the last seed and holds the result for transfer.
// Depends on nsv_pkg.
module nsv_out #(
    parameter int MAX_SEEDS = nsv_pkg::MAX_SEEDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          in_valid,
    input  nsv_pkg::nsv_item_t            in_item,
    input  logic                          active_last,
    output logic                          m_tvalid,
    output logic [nsv_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                          valid_reg;
    logic [nsv_pkg::M_TDATA_W-1:0] data_reg;
    nsv_pkg::nsv_item_t            folded;

    assign folded = nsv_pkg::fold_seed(in_item, (MAX_SEEDS == 1), active_last,
                                       nsv_pkg::IDX_W'(MAX_SEEDS - 1));

    // Keep queries only; loads end here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid && (in_item.func == nsv_pkg::FUNC_QUERY);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= {folded.best_dist, folded.best_idx, folded.best_lab};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
